[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

[rtl/core/cle_pkg.sv]
package cle_pkg;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_BUFFERED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COOKED  = 1'd1;

	localparam logic [1:0] REQ_KEY     = 2'd0;
	localparam logic [1:0] REQ_OUTPUT  = 2'd1;
	localparam logic [1:0] REQ_FLUSH   = 2'd2;
	localparam logic [1:0] REQ_RELEASE = 2'd3;

	// most results one request may produce
	localparam int MAX_RESULTS = 34;

	localparam int QDEPTH = 2;

	localparam logic [7:0] CH_BEL    = 8'h07;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DEL    = 8'h7F;

	typedef enum logic [2:0] {
		OP_RAW_KEY,
		OP_OUT_RAW,
		OP_OUT_COOKED,
		OP_KEY_STORE,
		OP_KEY_RUB,
		OP_KEY_CR,
		OP_FLUSH,
		OP_RELEASE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

endpackage

[rtl/core/cle_front.sv]
module cle_front
	import cle_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,
	input  logic [1:0]           s_tuser,
	output logic                 push,
	output cmd_t                 cmd,
	input  logic                 full
);

	logic buffered_q;
	logic cooked_q;
	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_next;
	logic accept;

	assign s_tready = !valid_s1 || !full;
	assign accept   = s_tvalid && s_tready;
	assign push     = valid_s1 && !full;
	assign cmd      = cmd_s1;

	always_comb begin
		cmd_next.data = s_tdata;
		case (s_tuser)
			REQ_KEY: begin
				if (!buffered_q) begin
					cmd_next.op = OP_RAW_KEY;
				end else if (s_tdata inside {CH_BS, CH_DEL}) begin
					cmd_next.op = OP_KEY_RUB;
				end else if (s_tdata == CH_CR) begin
					cmd_next.op = OP_KEY_CR;
				end else begin
					cmd_next.op = OP_KEY_STORE;
				end
			end
			REQ_OUTPUT: cmd_next.op = cooked_q ? OP_OUT_COOKED : OP_OUT_RAW;
			REQ_FLUSH:  cmd_next.op = OP_FLUSH;
			default:    cmd_next.op = OP_RELEASE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffered_q <= 1'b1;
			cooked_q   <= 1'b1;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_INPUT_BUFFERED: buffered_q <= cfg_data;
					CFG_OUTPUT_COOKED:  cooked_q   <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_next;
		end
	end

endmodule

[rtl/core/cle_fifo.sv]
module cle_fifo
	import cle_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	input  logic pop,
	output cmd_t dout,
	output logic empty
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	cmd_t          mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

[rtl/core/cle_back.sv]
module cle_back
	import cle_pkg::*;
#(
	parameter int LINE_MAX = 32,
	parameter int FW       = $clog2(LINE_MAX + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  cmd_t          cmd,
	output logic          pop,
	output logic [FW-1:0] fill,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,
	output logic          m_tuser,
	output logic          m_tlast
);

	localparam int AW = $clog2(LINE_MAX);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUB_RD,
		ST_SEQ,
		ST_DLV_RD,
		ST_DLV_OUT
	} state_t;

	typedef enum logic [1:0] {
		SEQ_PLAIN,
		SEQ_COOKED,
		SEQ_RUB
	} seq_kind_t;

	state_t        state_q;
	seq_kind_t     kind_q;
	logic [7:0]    byte_q;
	logic          dst_q;
	logic [3:0]    idx_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] dlv_cnt_q;
	logic [FW-1:0] dlv_idx_q;
	logic          m_tvalid_q;
	logic [7:0]    m_tdata_q;
	logic          m_tuser_q;
	logic          m_tlast_q;

	logic [7:0]    store [LINE_MAX];
	logic [7:0]    rdata_q;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic          re;
	logic [AW-1:0] raddr;

	logic          out_free;
	logic          out_load;
	logic          has_room;
	logic [FW-1:0] fill_dec;
	logic [3:0]    len;
	logic [7:0]    ch;
	logic          seq_end;

	function automatic logic [2:0] cell_width(input logic [7:0] b);
		if (b >= CH_SP && b < CH_DEL) begin
			return 3'd1;
		end else if (b < CH_SP) begin
			return 3'd2;
		end
		return 3'd4;
	endfunction

	function automatic logic [3:0] seq_len(input seq_kind_t k, input logic [7:0] b);
		logic [3:0] w;
		w = {1'b0, cell_width(b)};
		case (k)
			SEQ_COOKED: return w;
			SEQ_RUB:    return 4'((w << 1) + w);
			default:    return 4'd1;
		endcase
	endfunction

	function automatic logic [7:0] seq_char(input seq_kind_t k, input logic [7:0] b,
		input logic [3:0] i);
		logic [3:0] w;
		w = {1'b0, cell_width(b)};
		case (k)
			SEQ_COOKED: begin
				if (b >= CH_SP && b < CH_DEL) begin
					return b;
				end else if (b == CH_LF) begin
					return (i == 4'd0) ? CH_CR : CH_LF;
				end else if (b < CH_SP) begin
					return (i == 4'd0) ? CH_CARET : 8'(CH_AT + b);
				end
				case (i)
					4'd0:    return CH_BSLASH;
					4'd1:    return CH_ZERO + {6'd0, b[7:6]};
					4'd2:    return CH_ZERO + {5'd0, b[5:3]};
					default: return CH_ZERO + {5'd0, b[2:0]};
				endcase
			end
			SEQ_RUB: begin
				if (i < w) begin
					return CH_BS;
				end else if (i < 4'(w << 1)) begin
					return CH_SP;
				end
				return CH_BS;
			end
			default: return b;
		endcase
	endfunction

	function automatic logic [FW-1:0] cap_cnt(input int n, input int lim);
		return FW'((n > lim) ? lim : n);
	endfunction

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;
	assign fill     = fill_q;

	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = out_free && (state_q == ST_SEQ || state_q == ST_DLV_OUT);
	assign has_room = (fill_q < FW'(LINE_MAX));
	assign fill_dec = fill_q - 1'b1;
	assign len      = seq_len(kind_q, byte_q);
	assign ch       = seq_char(kind_q, byte_q, idx_q);
	assign seq_end  = (idx_q == len - 1'b1);

	always_comb begin
		pop   = (state_q == ST_IDLE) && !empty;
		we    = pop && (cmd.op == OP_KEY_STORE || cmd.op == OP_KEY_CR) && has_room;
		waddr = fill_q[AW-1:0];
		wdata = (cmd.op == OP_KEY_CR) ? CH_LF : cmd.data;
		re    = 1'b0;
		raddr = dlv_idx_q[AW-1:0];
		if (pop && cmd.op == OP_KEY_RUB && fill_q != '0) begin
			re    = 1'b1;
			raddr = fill_dec[AW-1:0];
		end else if (state_q == ST_DLV_RD) begin
			re = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			store[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= store[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						idx_q     <= '0;
						dlv_idx_q <= '0;
						dst_q     <= (cmd.op == OP_RAW_KEY);
						case (cmd.op)
							OP_RAW_KEY, OP_OUT_RAW: begin
								kind_q    <= SEQ_PLAIN;
								byte_q    <= cmd.data;
								dlv_cnt_q <= '0;
								state_q   <= ST_SEQ;
							end
							OP_OUT_COOKED: begin
								kind_q    <= SEQ_COOKED;
								byte_q    <= cmd.data;
								dlv_cnt_q <= '0;
								state_q   <= ST_SEQ;
							end
							OP_KEY_STORE: begin
								if (has_room) begin
									fill_q <= fill_q + 1'b1;
									kind_q <= SEQ_COOKED;
									byte_q <= cmd.data;
								end else begin
									kind_q <= SEQ_PLAIN;
									byte_q <= CH_BEL;
								end
								dlv_cnt_q <= '0;
								state_q   <= ST_SEQ;
							end
							OP_KEY_RUB: begin
								dlv_cnt_q <= '0;
								if (fill_q == '0) begin
									kind_q  <= SEQ_PLAIN;
									byte_q  <= CH_BEL;
									state_q <= ST_SEQ;
								end else begin
									fill_q  <= fill_dec;
									kind_q  <= SEQ_RUB;
									state_q <= ST_RUB_RD;
								end
							end
							OP_KEY_CR: begin
								if (has_room) begin
									kind_q    <= SEQ_COOKED;
									byte_q    <= CH_LF;
									dlv_cnt_q <= cap_cnt(int'(fill_q) + 1, MAX_RESULTS - 2);
								end else begin
									kind_q    <= SEQ_PLAIN;
									byte_q    <= CH_BEL;
									dlv_cnt_q <= cap_cnt(int'(fill_q), MAX_RESULTS - 1);
								end
								fill_q  <= '0;
								state_q <= ST_SEQ;
							end
							OP_FLUSH: fill_q <= '0;
							default: begin
								if (fill_q != '0) begin
									dlv_cnt_q <= cap_cnt(int'(fill_q), MAX_RESULTS);
									state_q   <= ST_DLV_RD;
								end
								fill_q <= '0;
							end
						endcase
					end
				end
				ST_RUB_RD: begin
					byte_q  <= rdata_q;
					state_q <= ST_SEQ;
				end
				ST_SEQ: begin
					if (out_free) begin
						m_tdata_q  <= ch;
						m_tuser_q  <= dst_q;
						m_tlast_q  <= seq_end && (dlv_cnt_q == '0);
						if (seq_end) begin
							state_q <= (dlv_cnt_q == '0) ? ST_IDLE : ST_DLV_RD;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_DLV_RD: state_q <= ST_DLV_OUT;
				ST_DLV_OUT: begin
					if (out_free) begin
						m_tdata_q  <= rdata_q;
						m_tuser_q  <= 1'b1;
						m_tlast_q  <= (dlv_idx_q == dlv_cnt_q - 1'b1);
						if (dlv_idx_q == dlv_cnt_q - 1'b1) begin
							state_q <= ST_IDLE;
						end else begin
							dlv_idx_q <= dlv_idx_q + 1'b1;
							state_q   <= ST_DLV_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/console_line_editor_echo.sv]
// Terminal line discipline. Requests enter on the s_ stream (tuser = request kind:
// key, program output, flush, release; tdata = byte) and every emitted byte leaves
// on the m_ stream (tuser = 0 display, 1 line reader; tlast = final byte of the
// request). The front stage classifies a word into a register and parks it in a
// two-entry queue, so input is taken while the back end is still emitting. The
// back end dequeues a command while idle, then sends one byte per cycle while
// m_tready allows (1 to 4 for cooked bytes, 3 to 12 for an erase, the erase after
// a read of the erased byte from the line store); a delivered line reads each
// stored byte from the line store's separate read port before sending it. Flush and
// release of an empty line emit nothing. No clearing pass is needed after reset.
`include "assert_macros.svh"

module console_line_editor_echo
	import cle_pkg::*;
#(
	parameter int LINE_MAX = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,    // [7:0] data_byte
	input  logic [1:0]           s_tuser,    // [1:0] req_type
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,    // [7:0] out_byte
	output logic                 m_tuser,    // [0] destination
	output logic                 m_tlast
);

	localparam int FW = $clog2(LINE_MAX + 1);

	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_empty;
	cmd_t          q_din;
	cmd_t          q_dout;
	logic [FW-1:0] fill;

	cle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (q_push),
		.cmd       (q_din),
		.full      (q_full)
	);

	cle_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	cle_back #(
		.LINE_MAX (LINE_MAX),
		.FW       (FW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.cmd      (q_dout),
		.pop      (q_pop),
		.fill     (fill),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	`ASSERT_NEVER(a_queue_overflow, clk, arst_n, q_push && q_full, "push into full queue")
	`ASSERT_NEVER(a_queue_underflow, clk, arst_n, q_pop && q_empty, "pop from empty queue")
	`ASSERT_CLK(a_fill_range, clk, arst_n, fill <= FW'(LINE_MAX), "line fill beyond store")

endmodule
